/* sv/i2cm_pkg.sv */
`default_nettype none
package i2cm_pkg;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_WAIT  = 3'd4
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  localparam logic REG_START_STOP_HOLD = 1'b0;
  localparam logic REG_ACK_TIMEOUT     = 1'b1;

  localparam logic [15:0] START_STOP_HOLD_RST = 16'd10;
  localparam logic [7:0]  ACK_TIMEOUT_RST     = 8'd250;
  localparam logic [15:0] BIT_HOLD            = 16'd2;
  localparam logic [15:0] SAMPLE_HOLD         = 16'd1;

  // context handed from the sequencer to the phase decoder
  typedef struct packed {
    op_t         op;
    logic [4:0]  idx;
    logic [1:0]  sub;
    logic        tx_bit;
    logic        ack_n;
    logic        fail;
    logic [7:0]  rx;
    logic        clock_line;
    logic        data_line;
    logic [15:0] ss_hold;
  } ctx_t;

  typedef struct packed {
    logic        scl;
    logic        sda;
    logic        dir_in;
    logic [15:0] hold;
    logic [7:0]  rx_byte;
    logic        ack_error;
    logic        last;
  } phase_t;

endpackage
`default_nettype wire

/* sv/i2cm_cmd_if.sv */
`default_nettype none
interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic [7:0] line_bits;
  logic [7:0] ack_polls;

  modport source (output valid, opcode, tx_byte, send_ack, line_bits, ack_polls,
                  input ready);
  modport sink (input valid, opcode, tx_byte, send_ack, line_bits, ack_polls,
                output ready);
endinterface
`default_nettype wire

/* sv/i2cm_phase_if.sv */
`default_nettype none
interface i2cm_phase_if;
  logic        valid;
  logic        ready;
  logic        scl_level;
  logic        sda_level;
  logic        sda_is_input;
  logic [15:0] hold_ticks;
  logic [7:0]  rx_byte;
  logic        ack_error;
  logic        last;

  modport source (output valid, scl_level, sda_level, sda_is_input, hold_ticks,
                  rx_byte, ack_error, last, input ready);
  modport sink (input valid, scl_level, sda_level, sda_is_input, hold_ticks,
                rx_byte, ack_error, last, output ready);
endinterface
`default_nettype wire

/* sv/i2c_master_bit_sequencer.sv */
// a command is accepted into the context registers, then each phase from the phase decoder
// is registered into the output register, one phase per cycle unless phase.valid is held
// without phase.ready; a command keeps the sequencer busy until its last phase is stepped,
// and unknown opcodes are accepted and produce nothing
// reset: scl and sda released high, config registers at their defaults
`default_nettype none
module i2c_master_bit_sequencer
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  i2cm_cmd_if.sink         cmd,
  i2cm_phase_if.source     phase,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  state_t      state;
  state_t      state_next;
  op_t         op;
  logic [4:0]  idx;
  logic [1:0]  sub;
  logic [7:0]  sh;
  logic        ack_n;
  logic        fail;
  logic [7:0]  rx;
  logic        clock_line;
  logic        data_line;
  logic [15:0] ss_hold;
  logic [7:0]  ack_to;
  logic        step;
  logic        cmd_take;
  logic        cmd_known;
  ctx_t        ctx;
  phase_t      ph;

  assign ctx = '{op: op, idx: idx, sub: sub, tx_bit: sh[7], ack_n: ack_n,
                 fail: fail, rx: rx, clock_line: clock_line,
                 data_line: data_line, ss_hold: ss_hold};

  i2cm_phase_dec u_dec (
    .ctx (ctx),
    .ph  (ph)
  );

  assign cmd_known = (cmd.opcode <= OP_WAIT);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd.valid && cmd_known) state_next = ST_RUN;
      ST_RUN:  if (step && ph.last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready = (state == ST_IDLE);
    cmd_take  = cmd.valid && cmd.ready;
    step      = (state == ST_RUN) && (!phase.valid || phase.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase.valid <= 1'b0;
      clock_line  <= 1'b1;
      data_line   <= 1'b1;
      ss_hold     <= START_STOP_HOLD_RST;
      ack_to      <= ACK_TIMEOUT_RST;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_START_STOP_HOLD: ss_hold <= cfg_data;
          REG_ACK_TIMEOUT:     ack_to  <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (step) begin
        phase.valid <= 1'b1;
        clock_line  <= ph.scl;
        data_line   <= ph.sda;
      end else if (phase.ready) begin
        phase.valid <= 1'b0;
      end
    end
  end

  // command context and output payload
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      op    <= op_t'(cmd.opcode);
      idx   <= '0;
      sub   <= '0;
      sh    <= cmd.tx_byte;
      ack_n <= ~cmd.send_ack;
      fail  <= (cmd.ack_polls > ack_to);
      rx    <= cmd.line_bits;
    end else if (step) begin
      idx <= idx + 5'd1;
      if (sub == 2'd2) begin
        sub <= '0;
        sh  <= {sh[6:0], 1'b0};
      end else begin
        sub <= sub + 2'd1;
      end
    end
    if (step) begin
      phase.scl_level    <= ph.scl;
      phase.sda_level    <= ph.dir_in | ph.sda;
      phase.sda_is_input <= ph.dir_in;
      phase.hold_ticks   <= ph.hold;
      phase.rx_byte      <= ph.rx_byte;
      phase.ack_error    <= ph.ack_error;
      phase.last         <= ph.last;
    end
  end

endmodule
`default_nettype wire

/* sv/i2cm_phase_dec.sv */
`default_nettype none
module i2cm_phase_dec
  import i2cm_pkg::*;
(
  input  ctx_t   ctx,
  output phase_t ph
);

  logic [1:0] stop_idx;

  always_comb begin
    stop_idx = ctx.idx[1:0];
    ph = '0;
    unique case (ctx.op)
      OP_START: begin
        ph.last = (ctx.idx[1:0] == 2'd3);
        unique case (ctx.idx[1:0])
          2'd0: begin ph.scl = ctx.clock_line; ph.sda = 1'b1; end
          2'd1: begin ph.scl = 1'b1; ph.sda = 1'b1; ph.hold = ctx.ss_hold; end
          2'd2: begin ph.scl = 1'b1; ph.sda = 1'b0; ph.hold = ctx.ss_hold; end
          default: begin ph.scl = 1'b0; ph.sda = 1'b0; end
        endcase
      end
      OP_WRITE: begin
        ph.scl  = (ctx.sub == 2'd1);
        ph.sda  = ctx.tx_bit;
        ph.hold = BIT_HOLD;
        ph.last = (ctx.idx == 5'd23);
      end
      OP_READ: begin
        priority if (!ctx.idx[4]) begin
          // eight sample clocks with sda released
          ph.scl    = ctx.idx[0];
          ph.sda    = ctx.data_line;
          ph.dir_in = 1'b1;
          ph.hold   = ctx.idx[0] ? SAMPLE_HOLD : BIT_HOLD;
        end else if (ctx.idx[1:0] == 2'd0) begin
          ph.sda  = ctx.ack_n;
          ph.hold = BIT_HOLD;
        end else if (ctx.idx[1:0] == 2'd1) begin
          ph.scl  = 1'b1;
          ph.sda  = ctx.ack_n;
          ph.hold = BIT_HOLD;
        end else begin
          ph.sda     = ctx.ack_n;
          ph.last    = 1'b1;
          ph.rx_byte = ctx.rx;
        end
      end
      OP_STOP, OP_WAIT: begin
        priority if (ctx.op == OP_WAIT && ctx.idx < 5'd2) begin
          ph.scl    = ctx.idx[0] ? 1'b1 : ctx.clock_line;
          ph.sda    = 1'b1;
          ph.dir_in = 1'b1;
          ph.hold   = SAMPLE_HOLD;
        end else if (ctx.op == OP_WAIT && !ctx.fail) begin
          ph.sda    = 1'b1;
          ph.dir_in = 1'b1;
          ph.last   = 1'b1;
        end else begin
          // stop condition, shifted by two phases after a failed poll
          if (ctx.op == OP_WAIT) begin
            stop_idx = ctx.idx[1:0] - 2'd2;
          end
          ph.last      = (stop_idx == 2'd3);
          ph.ack_error = (stop_idx == 2'd3) && (ctx.op == OP_WAIT);
          unique case (stop_idx)
            2'd0: begin ph.scl = ctx.clock_line; ph.sda = 1'b0; end
            2'd1: begin ph.scl = 1'b0; ph.sda = 1'b0; ph.hold = ctx.ss_hold; end
            2'd2: begin ph.scl = 1'b1; ph.sda = 1'b0; end
            default: begin ph.scl = 1'b1; ph.sda = 1'b1; ph.hold = ctx.ss_hold; end
          endcase
        end
      end
      default: ph = '0;
    endcase
  end

endmodule
`default_nettype wire
